// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// needs clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mvt_pkg.sv -----
// types and constants for the 4x4 matrix vector transform
// no dependencies
package mvt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W = PROD_W + 2;
	localparam int CFG_W = 64;
	localparam int CFG_NUM = 8;
	localparam int CFG_IDX_W = 4;
	localparam int LANES = 4;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// identity matrix after reset
	localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic signed [DATA_W-1:0] in_x;
		logic signed [DATA_W-1:0] in_y;
		logic signed [DATA_W-1:0] in_z;
		logic signed [DATA_W-1:0] in_w;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic signed [DATA_W-1:0] out_w;
		logic saturated;
	} out_t;

	typedef logic [LANES-1:0][DATA_W-1:0] vec4_t;
	typedef logic [LANES-1:0][SUM_W-1:0] sum4_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_en_t;

endpackage

// ----- rtl/mvt_lane.sv -----
// one row lane: four products, pair sums, full sum of the dot product
// depends on mvt_pkg
module mvt_lane (
	input  logic              clk,
	input  mvt_pkg::pipe_en_t en,
	input  mvt_pkg::vec4_t    row_elem,
	input  mvt_pkg::vec4_t    vec,
	output logic [mvt_pkg::SUM_W-1:0] sum_s3
);

	logic signed [mvt_pkg::PROD_W-1:0] prod_s1 [mvt_pkg::LANES];
	logic signed [mvt_pkg::PAIR_W-1:0] pair_s2 [2];

	always_ff @(posedge clk) begin
		if (en.en1) begin
			for (int c = 0; c < mvt_pkg::LANES; c++) begin
				prod_s1[c] <= $signed(row_elem[c]) * $signed(vec[c]);
			end
		end
		if (en.en2) begin
			pair_s2[0] <= {prod_s1[0][mvt_pkg::PROD_W-1], prod_s1[0]}
				+ {prod_s1[1][mvt_pkg::PROD_W-1], prod_s1[1]};
			pair_s2[1] <= {prod_s1[2][mvt_pkg::PROD_W-1], prod_s1[2]}
				+ {prod_s1[3][mvt_pkg::PROD_W-1], prod_s1[3]};
		end
		if (en.en3) begin
			sum_s3 <= {pair_s2[0][mvt_pkg::PAIR_W-1], pair_s2[0]}
				+ {pair_s2[1][mvt_pkg::PAIR_W-1], pair_s2[1]};
		end
	end

endmodule

// ----- rtl/mvt_merge.sv -----
// merge stage: scales and clamps each lane sum, combines the clip flags,
// holds the output register; depends on mvt_pkg
module mvt_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                lane_valid,
	input  mvt_pkg::sum4_t      lane_sum,
	output logic                ready,
	output logic                out_valid,
	input  logic                out_stall,
	output mvt_pkg::out_t       out_data
);

	logic signed [mvt_pkg::SUM_W-1:0] scaled [mvt_pkg::LANES];
	logic [mvt_pkg::DATA_W-1:0] clamped [mvt_pkg::LANES];
	logic [mvt_pkg::LANES-1:0] clip;
	logic out_valid_q;
	mvt_pkg::out_t out_q;

	assign ready = !out_valid_q || !out_stall;

	always_comb begin
		for (int i = 0; i < mvt_pkg::LANES; i++) begin
			scaled[i] = $signed(lane_sum[i]) >>> mvt_pkg::FRAC_BITS;
			// in range when all bits above the result's sign agree with it
			clip[i] = !((&scaled[i][mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1])
				|| !(|scaled[i][mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1]));
			if (!clip[i]) begin
				clamped[i] = scaled[i][mvt_pkg::DATA_W-1:0];
			end else if (scaled[i][mvt_pkg::SUM_W-1]) begin
				clamped[i] = mvt_pkg::SAT_MIN;
			end else begin
				clamped[i] = mvt_pkg::SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready) begin
			out_valid_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && lane_valid) begin
			out_q.out_x <= clamped[0];
			out_q.out_y <= clamped[1];
			out_q.out_z <= clamped[2];
			out_q.out_w <= clamped[3];
			out_q.saturated <= |clip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ----- rtl/vec4_matrix_transform.sv -----
// path from input transfer to result valid: products, pair sums, full sum,
// then scale and clamp into the output register
// throughput: one vector per cycle unless out_stall holds; the four row lanes run side by side
// reset: matrix registers return to the identity, pipeline empties
// depends on mvt_pkg, mvt_lane, mvt_merge
module vec4_matrix_transform (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mvt_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mvt_pkg::out_t                  out_data,
	input  logic                           cfg_we,
	input  logic [mvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mvt_pkg::CFG_W-1:0]      cfg_data
);

	logic [mvt_pkg::CFG_W-1:0] cfg_q [mvt_pkg::CFG_NUM];
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3, rdy_out;
	mvt_pkg::pipe_en_t en;
	mvt_pkg::vec4_t vec;
	mvt_pkg::vec4_t row_elem [mvt_pkg::LANES];
	mvt_pkg::sum4_t lane_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mvt_pkg::CFG_RESET;
		end else if (cfg_we && (cfg_index < mvt_pkg::CFG_IDX_W'(mvt_pkg::CFG_NUM))) begin
			cfg_q[cfg_index[$clog2(mvt_pkg::CFG_NUM)-1:0]] <= cfg_data;
		end
	end

	// a stage takes new data when it is empty or its contents move on
	assign rdy3 = !v3_q || rdy_out;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign in_stall = !rdy1;

	assign en.en1 = rdy1;
	assign en.en2 = rdy2;
	assign en.en3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	assign vec[0] = in_data.in_x;
	assign vec[1] = in_data.in_y;
	assign vec[2] = in_data.in_z;
	assign vec[3] = in_data.in_w;

	for (genvar r = 0; r < mvt_pkg::LANES; r++) begin : g_lane
		// column-major storage, two rows per register
		for (genvar c = 0; c < mvt_pkg::LANES; c++) begin : g_col
			assign row_elem[r][c] =
				cfg_q[c*2 + r/2][(r%2)*mvt_pkg::DATA_W +: mvt_pkg::DATA_W];
		end

		mvt_lane u_lane (
			.clk      (clk),
			.en       (en),
			.row_elem (row_elem[r]),
			.vec      (vec),
			.sum_s3   (lane_sum[r])
		);
	end

	mvt_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (v3_q),
		.lane_sum   (lane_sum),
		.ready      (rdy_out),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ----- rtl/mvt_checker.sv -----
// port-level checks for vec4_matrix_transform, attached by bind
// depends on mvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module mvt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input mvt_pkg::out_t out_data
);

	logic any_clamp_value;

	assign any_clamp_value =
		(out_data.out_x == mvt_pkg::SAT_MAX) || (out_data.out_x == mvt_pkg::SAT_MIN) ||
		(out_data.out_y == mvt_pkg::SAT_MAX) || (out_data.out_y == mvt_pkg::SAT_MIN) ||
		(out_data.out_z == mvt_pkg::SAT_MAX) || (out_data.out_z == mvt_pkg::SAT_MIN) ||
		(out_data.out_w == mvt_pkg::SAT_MAX) || (out_data.out_w == mvt_pkg::SAT_MIN);

	// a stalled result stays put until its transfer
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

	// with the output side empty the input must not back up
	`ASSERT_IMPLIES(a_no_stall_empty, !out_valid, !in_stall, "input stalled with empty output")

	// a clip flag goes with at least one clamped component
	`ASSERT_IMPLIES(a_sat_value, out_valid && out_data.saturated, any_clamp_value, "saturated flag without clamped value")

	// an accepted vector with a free output side shows up as a result
	`ASSERT_IMPLIES(a_flow, in_valid && !in_stall && !out_stall, ##4 out_valid, "accepted item did not arrive")

endmodule

bind vec4_matrix_transform mvt_checker u_mvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- tb/tb_vec4_matrix_transform.sv -----
`timescale 1ns / 1ps
// testbench for vec4_matrix_transform: directed and random vertex streams against
// a local fixed-point predictor, with random idling on both channels
// depends on mvt_pkg and the vec4_matrix_transform rtl
module tb_vec4_matrix_transform;

	localparam int ACC_W = 96;
	localparam int VERTS_PER_MATRIX = 100;
	localparam int MATRICES_PER_PHASE = 5;
	localparam int DRAIN_CYCLES = 16;
	localparam int TIMEOUT_NS = 400_000;
	localparam logic signed [ACC_W-1:0] POS_LIMIT =
		$signed({{(ACC_W-mvt_pkg::DATA_W){1'b0}}, mvt_pkg::SAT_MAX});
	localparam logic signed [ACC_W-1:0] NEG_LIMIT =
		$signed({{(ACC_W-mvt_pkg::DATA_W){1'b1}}, mvt_pkg::SAT_MIN});
	localparam logic [mvt_pkg::DATA_W-1:0] ONE_Q = 1 << mvt_pkg::FRAC_BITS;
	localparam logic [mvt_pkg::DATA_W-1:0] HALF_Q = 1 << (mvt_pkg::FRAC_BITS - 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mvt_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mvt_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [mvt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mvt_pkg::CFG_W-1:0] cfg_data = '0;

	logic [mvt_pkg::CFG_W-1:0] cfg_model [mvt_pkg::CFG_NUM];
	logic [mvt_pkg::CFG_W-1:0] staged_mat [mvt_pkg::CFG_NUM];
	mvt_pkg::out_t pending_results [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_cnt = 0;

	vec4_matrix_transform DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic signed [mvt_pkg::DATA_W-1:0] matrix_elem(input int col,
			input int row);
		logic [mvt_pkg::CFG_W-1:0] word;
		word = cfg_model[col * 2 + row / 2];
		return (row % 2) ? word[mvt_pkg::CFG_W-1:mvt_pkg::DATA_W] : word[mvt_pkg::DATA_W-1:0];
	endfunction

	// exact wide sum, floor shift, then clamp each row to 32 bits
	function automatic mvt_pkg::out_t transform_vertex(input mvt_pkg::in_t v);
		logic signed [mvt_pkg::DATA_W-1:0] comp [mvt_pkg::LANES];
		logic [mvt_pkg::DATA_W-1:0] row_val [mvt_pkg::LANES];
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] lhs;
		logic signed [ACC_W-1:0] rhs;
		logic clipped;
		mvt_pkg::out_t res;
		comp[0] = v.in_x;
		comp[1] = v.in_y;
		comp[2] = v.in_z;
		comp[3] = v.in_w;
		clipped = 1'b0;
		for (int r = 0; r < mvt_pkg::LANES; r++) begin
			acc = '0;
			for (int c = 0; c < mvt_pkg::LANES; c++) begin
				lhs = matrix_elem(c, r);
				rhs = comp[c];
				acc = acc + lhs * rhs;
			end
			acc = acc >>> mvt_pkg::FRAC_BITS;
			if (acc > POS_LIMIT) begin
				row_val[r] = mvt_pkg::SAT_MAX;
				clipped = 1'b1;
			end else if (acc < NEG_LIMIT) begin
				row_val[r] = mvt_pkg::SAT_MIN;
				clipped = 1'b1;
			end else begin
				row_val[r] = acc[mvt_pkg::DATA_W-1:0];
			end
		end
		res.out_x = row_val[0];
		res.out_y = row_val[1];
		res.out_z = row_val[2];
		res.out_w = row_val[3];
		res.saturated = clipped;
		return res;
	endfunction

	// mostly small magnitudes so that plenty of results stay in range
	function automatic logic [mvt_pkg::DATA_W-1:0] rand_word();
		logic [mvt_pkg::DATA_W-1:0] val;
		case ($urandom_range(9))
			0, 1: val = $urandom;
			2: begin
				case ($urandom_range(4))
					0: val = '0;
					1: val = 1;
					2: val = '1;
					3: val = mvt_pkg::SAT_MAX;
					default: val = mvt_pkg::SAT_MIN;
				endcase
			end
			default: begin
				val = $urandom & ((1 << $urandom_range(20, 1)) - 1);
				if ($urandom_range(1))
					val = -val;
			end
		endcase
		return val;
	endfunction

	function automatic mvt_pkg::in_t make_vertex(input logic [mvt_pkg::DATA_W-1:0] x,
			input logic [mvt_pkg::DATA_W-1:0] y, input logic [mvt_pkg::DATA_W-1:0] z,
			input logic [mvt_pkg::DATA_W-1:0] w);
		mvt_pkg::in_t v;
		v.in_x = x;
		v.in_y = y;
		v.in_z = z;
		v.in_w = w;
		return v;
	endfunction

	function automatic void set_staged(input int col, input int row,
			input logic [mvt_pkg::DATA_W-1:0] val);
		if (row % 2)
			staged_mat[col * 2 + row / 2][mvt_pkg::CFG_W-1:mvt_pkg::DATA_W] = val;
		else
			staged_mat[col * 2 + row / 2][mvt_pkg::DATA_W-1:0] = val;
	endfunction

	function automatic void fill_staged(input logic [mvt_pkg::DATA_W-1:0] val);
		for (int i = 0; i < mvt_pkg::CFG_NUM; i++)
			staged_mat[i] = {val, val};
	endfunction

	always @(posedge clk) begin
		mvt_pkg::out_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", out_data);
				fail_cnt++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_data.out_x !== exp_res.out_x) begin
					$error("out_x expected %h, got %h", exp_res.out_x, out_data.out_x);
					fail_cnt++;
				end
				if (out_data.out_y !== exp_res.out_y) begin
					$error("out_y expected %h, got %h", exp_res.out_y, out_data.out_y);
					fail_cnt++;
				end
				if (out_data.out_z !== exp_res.out_z) begin
					$error("out_z expected %h, got %h", exp_res.out_z, out_data.out_z);
					fail_cnt++;
				end
				if (out_data.out_w !== exp_res.out_w) begin
					$error("out_w expected %h, got %h", exp_res.out_w, out_data.out_w);
					fail_cnt++;
				end
				if (out_data.saturated !== exp_res.saturated) begin
					$error("saturated expected %b, got %b", exp_res.saturated,
						out_data.saturated);
					fail_cnt++;
				end
			end
		end
	end

	task automatic reset_dut();
		for (int i = 0; i < mvt_pkg::CFG_NUM; i++)
			cfg_model[i] = mvt_pkg::CFG_RESET[i];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic send_vertex(input mvt_pkg::in_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pending_results.push_back(transform_vertex(v));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_we high so back-to-back writes need one assignment per edge
	task automatic write_reg(input int idx, input logic [mvt_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= mvt_pkg::CFG_IDX_W'(idx);
		cfg_data <= data;
		@(posedge clk);
		if (idx < mvt_pkg::CFG_NUM)
			cfg_model[idx] = data;
	endtask

	task automatic load_matrix();
		for (int i = 0; i < mvt_pkg::CFG_NUM; i++)
			write_reg(i, staged_mat[i]);
		cfg_we <= 1'b0;
	endtask

	// starts right after reset with the input side already idle
	task automatic test_identity_passthrough();
		send_vertex(make_vertex('0, '0, '0, '0));
		send_vertex(make_vertex(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
			mvt_pkg::SAT_MAX));
		send_vertex(make_vertex(mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
			mvt_pkg::SAT_MIN));
		send_vertex(make_vertex('1, 1, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX));
		send_vertex(make_vertex(ONE_Q, -ONE_Q, HALF_Q, $urandom));
	endtask

	task automatic test_saturation();
		wait_idle();
		fill_staged(mvt_pkg::SAT_MAX);
		load_matrix();
		send_vertex(make_vertex(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
			mvt_pkg::SAT_MAX));
		send_vertex(make_vertex(mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
			mvt_pkg::SAT_MIN));
		// lands exactly on the top of the range
		send_vertex(make_vertex(ONE_Q, '0, '0, '0));
		wait_idle();
		fill_staged(mvt_pkg::SAT_MIN);
		load_matrix();
		// four products of 2^62 need more than 64 bits of sum
		send_vertex(make_vertex(mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
			mvt_pkg::SAT_MIN));
		// lands exactly on the bottom of the range
		send_vertex(make_vertex(ONE_Q, '0, '0, '0));
		send_vertex(make_vertex(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
			mvt_pkg::SAT_MAX));
		wait_idle();
		// only row 0 clips; rows 2 and 3 are all ones
		fill_staged('0);
		for (int c = 0; c < mvt_pkg::LANES; c++) begin
			set_staged(c, 0, mvt_pkg::SAT_MAX);
			set_staged(c, 2, '1);
			set_staged(c, 3, '1);
		end
		load_matrix();
		send_vertex(make_vertex(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
			mvt_pkg::SAT_MAX));
		send_vertex(make_vertex(ONE_Q, ONE_Q, '0, '0));
	endtask

	task automatic test_floor_rounding();
		wait_idle();
		fill_staged('0);
		for (int d = 0; d < mvt_pkg::LANES; d++)
			set_staged(d, d, HALF_Q);
		load_matrix();
		// halves of odd values round toward minus infinity
		send_vertex(make_vertex(1, '1, 3, -3));
		send_vertex(make_vertex(-ONE_Q - 1, ONE_Q + 1, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX));
	endtask

	task automatic test_unused_index();
		wait_idle();
		for (int i = 0; i < mvt_pkg::CFG_NUM; i++)
			staged_mat[i] = mvt_pkg::CFG_RESET[i];
		// the unused indexes follow the matrix writes without a gap
		for (int i = 0; i < mvt_pkg::CFG_NUM; i++)
			write_reg(i, staged_mat[i]);
		for (int idx = mvt_pkg::CFG_NUM; idx < (1 << mvt_pkg::CFG_IDX_W); idx++)
			write_reg(idx, {$urandom, $urandom});
		cfg_we <= 1'b0;
		send_vertex(make_vertex($urandom, $urandom, $urandom, $urandom));
		send_vertex(make_vertex(ONE_Q, -ONE_Q, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN));
		send_vertex(make_vertex(rand_word(), rand_word(), rand_word(), rand_word()));
	endtask

	task automatic test_random_stream();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int m = 0; m < MATRICES_PER_PHASE; m++) begin
				wait_idle();
				for (int c = 0; c < mvt_pkg::LANES; c++)
					for (int r = 0; r < mvt_pkg::LANES; r++)
						set_staged(c, r, (m == 0)
							? ($urandom_range(1) ? mvt_pkg::SAT_MAX : mvt_pkg::SAT_MIN)
							: (m == 1) ? mvt_pkg::DATA_W'($urandom) : rand_word());
				load_matrix();
				for (int n = 0; n < VERTS_PER_MATRIX; n++)
					send_vertex(make_vertex(rand_word(), rand_word(), rand_word(),
						rand_word()));
			end
		end
	endtask

	initial begin
		reset_dut();
		test_identity_passthrough();
		test_saturation();
		test_floor_rounding();
		test_unused_index();
		send_idle_pct = 37;
		recv_idle_pct = 61;
		test_random_stream();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("PASS vec4_matrix_transform");
		else
			$display("FAIL vec4_matrix_transform");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL vec4_matrix_transform");
		$finish;
	end

endmodule
